@@ rtl/scbpa_pkg.sv @@
// Package for the size-class block pool allocator.
// Types, widths, codes and controller/datapath interface structs; no dependencies.
`default_nettype none
package scbpa_pkg;

  localparam int MAX_POOLS      = 8;
  localparam int SLOT_W         = 3;
  localparam int MAX_BLOCKS     = 256;
  localparam int IDX_W          = 8;
  localparam int CNT_W          = 9;
  localparam int SIZE_W         = 13;
  localparam int MAX_BLOCK_SIZE = 4096;
  localparam int ADDR_W         = 23;
  localparam int BUMP_W         = 24;
  localparam int REGION_W       = SIZE_W + CNT_W;
  localparam int PROD_W         = SIZE_W + IDX_W;
  localparam int STACK_AW       = SLOT_W + IDX_W;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_SPACE_FULL = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_BAD_SIZE   = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_CREATE, S_SERVE, S_MUL, S_ADDR, S_DIV, S_FCHECK, S_DONE
  } state_e;

  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   alloc_size;
    logic [ADDR_W-1:0]   free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [ADDR_W-1:0]   block_address;
    logic [SLOT_W-1:0]   pool_index;
    logic [CNT_W-1:0]    free_count;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    look;
    logic    create;
    logic    serve;
    logic    mul;
    logic    div_step;
    logic    push;
    logic    fin;
    status_e fin_code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic hit;
    logic exhausted;
    logic found;
    logic have_slot;
    logic space_ok;
    logic div_last;
    logic fcheck_ok;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/scbpa_ctrl.sv @@
// Controller state machine for the block pool allocator.
// Depends on scbpa_pkg; drives commands into scbpa_dp.
`default_nettype none
module scbpa_ctrl import scbpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output logic commit_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.fin_code = ST_OK;
    in_ready_o = 1'b0;
    commit_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_free) begin
          if (sts_i.found) begin
            state_d = S_DIV;
          end else begin
            cmd_o.fin = 1'b1;
            cmd_o.fin_code = ST_UNKNOWN;
            state_d = S_DONE;
          end
        end else if (sts_i.bad_size) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_code = ST_BAD_SIZE;
          state_d = S_DONE;
        end else if (sts_i.hit) begin
          if (sts_i.exhausted) begin
            cmd_o.fin = 1'b1;
            cmd_o.fin_code = ST_EXHAUSTED;
            state_d = S_DONE;
          end else begin
            state_d = S_SERVE;
          end
        end else begin
          state_d = S_CREATE;
        end
      end
      S_CREATE: begin
        if (!sts_i.have_slot) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_code = ST_TABLE_FULL;
          state_d = S_DONE;
        end else if (!sts_i.space_ok) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_code = ST_SPACE_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.create = 1'b1;
          state_d = S_SERVE;
        end
      end
      S_SERVE: begin
        cmd_o.serve = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.fin = 1'b1;
        cmd_o.fin_code = ST_OK;
        state_d = S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FCHECK;
      end
      S_FCHECK: begin
        cmd_o.fin = 1'b1;
        if (sts_i.fcheck_ok) begin
          cmd_o.push = 1'b1;
          cmd_o.fin_code = ST_OK;
        end else begin
          cmd_o.fin_code = ST_UNKNOWN;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          commit_o = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/scbpa_dp.sv @@
// Datapath: pool table, freed-index stack memory, multiplier, serial divider.
// Depends on scbpa_pkg; sequenced by scbpa_ctrl.
`default_nettype none
module scbpa_dp import scbpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  req_t             req_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output rsp_t             rsp_o
);

  logic [CNT_W-1:0]  bpp_q;
  logic [MAX_POOLS-1:0] valid_q;
  logic [SIZE_W-1:0] bsize_q [MAX_POOLS];
  logic [ADDR_W-1:0] base_q  [MAX_POOLS];
  logic [BUMP_W-1:0] end_q   [MAX_POOLS];
  logic [CNT_W-1:0]  next_q  [MAX_POOLS];
  logic [CNT_W-1:0]  free_q  [MAX_POOLS];
  logic [CNT_W-1:0]  total_q [MAX_POOLS];
  logic [CNT_W-1:0]  depth_q [MAX_POOLS];
  logic [BUMP_W-1:0] bump_q;

  logic [IDX_W-1:0]  stack_mem [MAX_POOLS*MAX_BLOCKS];
  logic [IDX_W-1:0]  rd_q;

  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SLOT_W-1:0] slot_q;
  logic              bad_q, hit_q, found_q, have_slot_q, use_stack_q;
  logic [REGION_W-1:0] region_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] prod_q;
  logic [ADDR_W-1:0] rem_q;
  logic [PROD_W-1:0] dsr_q;
  logic [2:0]        dcnt_q;
  rsp_t              rsp_q;

  logic [CNT_W-1:0]  nb;
  logic              hit_c, free_c, match_c;
  logic [SLOT_W-1:0] hit_s, free_s, match_s;
  logic [ADDR_W:0]   rem_diff;
  logic [BUMP_W:0]   space_sum;
  rsp_t              fin_rsp;

  // clamp the configured block count into 1..MAX_BLOCKS
  always_comb begin
    if (bpp_q == '0) nb = CNT_W'(1);
    else if (bpp_q > CNT_W'(MAX_BLOCKS)) nb = CNT_W'(MAX_BLOCKS);
    else nb = bpp_q;
  end

  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; match_c = 1'b0;
    hit_s = '0; free_s = '0; match_s = '0;
    for (int s = MAX_POOLS - 1; s >= 0; s--) begin
      if (valid_q[s] && bsize_q[s] == size_q) begin
        hit_c = 1'b1; hit_s = SLOT_W'(s);
      end
      if (!valid_q[s]) begin
        free_c = 1'b1; free_s = SLOT_W'(s);
      end
      if (valid_q[s] && addr_q >= base_q[s] && {1'b0, addr_q} < end_q[s]) begin
        match_c = 1'b1; match_s = SLOT_W'(s);
      end
    end
  end

  assign rem_diff  = {1'b0, rem_q} - {(ADDR_W + 1 - PROD_W)'(0), dsr_q};
  assign space_sum = {1'b0, bump_q} + (BUMP_W + 1)'(region_q);

  assign sts_o.is_free   = cmd_q;
  assign sts_o.bad_size  = bad_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.exhausted = (free_q[slot_q] == '0);
  assign sts_o.found     = found_q;
  assign sts_o.have_slot = have_slot_q;
  assign sts_o.space_ok  = space_sum <= (BUMP_W + 1)'(1 << ADDR_W);
  assign sts_o.div_last  = (dcnt_q == 3'd7);
  assign sts_o.fcheck_ok = ({1'b0, idx_q} < next_q[slot_q]) &&
                           (free_q[slot_q] < total_q[slot_q]) &&
                           (depth_q[slot_q] < CNT_W'(MAX_BLOCKS));
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= CNT_W'(MAX_BLOCKS);
      valid_q <= '0;
      bump_q  <= '0;
      for (int s = 0; s < MAX_POOLS; s++) begin
        bsize_q[s] <= '0; base_q[s] <= '0; end_q[s] <= '0; next_q[s] <= '0;
        free_q[s] <= '0; total_q[s] <= '0; depth_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) bpp_q <= cfg_data_i;
      if (cmd_i.create) begin
        valid_q[slot_q] <= 1'b1;
        bsize_q[slot_q] <= size_q;
        base_q[slot_q]  <= bump_q[ADDR_W-1:0];
        end_q[slot_q]   <= space_sum[BUMP_W-1:0];
        next_q[slot_q]  <= '0;
        free_q[slot_q]  <= nb;
        total_q[slot_q] <= nb;
        depth_q[slot_q] <= '0;
        bump_q          <= space_sum[BUMP_W-1:0];
      end
      if (cmd_i.serve) begin
        free_q[slot_q] <= free_q[slot_q] - CNT_W'(1);
        if (depth_q[slot_q] != '0) depth_q[slot_q] <= depth_q[slot_q] - CNT_W'(1);
        else next_q[slot_q] <= next_q[slot_q] + CNT_W'(1);
      end
      if (cmd_i.push) begin
        free_q[slot_q]  <= free_q[slot_q] + CNT_W'(1);
        depth_q[slot_q] <= depth_q[slot_q] + CNT_W'(1);
      end
    end
  end

  // stack memory: pop reads at depth-1, push writes at depth
  always_ff @(posedge clk_i) begin
    if (cmd_i.serve) begin
      rd_q <= stack_mem[{slot_q, IDX_W'(depth_q[slot_q] - CNT_W'(1))}];
    end
    if (cmd_i.push) begin
      stack_mem[{slot_q, depth_q[slot_q][IDX_W-1:0]}] <= idx_q;
    end
  end

  // result item for the finishing request
  always_comb begin
    fin_rsp        = '0;
    fin_rsp.status = cmd_i.fin_code;
    if (cmd_i.fin_code == ST_EXHAUSTED) begin
      fin_rsp.pool_index = slot_q;
    end else if (cmd_i.fin_code == ST_OK) begin
      fin_rsp.pool_index = slot_q;
      if (cmd_q == CMD_FREE) begin
        fin_rsp.free_count = free_q[slot_q] + CNT_W'(1);
      end else begin
        fin_rsp.free_count    = free_q[slot_q];
        fin_rsp.block_address = base_q[slot_q] + ADDR_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= req_i.command;
      size_q <= req_i.alloc_size;
      addr_q <= req_i.free_address;
    end
    if (cmd_i.look) begin
      bad_q       <= (size_q == '0) || (size_q > SIZE_W'(MAX_BLOCK_SIZE));
      hit_q       <= hit_c;
      have_slot_q <= free_c;
      found_q     <= match_c;
      region_q    <= REGION_W'(size_q) * REGION_W'(nb);
      if (cmd_q == CMD_FREE) slot_q <= match_s;
      else slot_q <= hit_c ? hit_s : free_s;
      rem_q  <= addr_q - base_q[match_s];
      dsr_q  <= {bsize_q[match_s], {IDX_W-1{1'b0}}, 1'b0} >> 1;
      dcnt_q <= '0;
    end
    if (cmd_i.serve) begin
      use_stack_q <= (depth_q[slot_q] != '0);
      idx_q       <= next_q[slot_q][IDX_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(use_stack_q ? rd_q : idx_q) * PROD_W'(bsize_q[slot_q]);
    end
    // restoring divide: one quotient bit per step, MSB first
    if (cmd_i.div_step) begin
      if (!rem_diff[ADDR_W]) rem_q <= rem_diff[ADDR_W-1:0];
      idx_q  <= {idx_q[IDX_W-2:0], !rem_diff[ADDR_W]};
      dsr_q  <= dsr_q >> 1;
      dcnt_q <= dcnt_q + 3'd1;
    end
    if (cmd_i.fin) rsp_q <= fin_rsp;
  end

endmodule
`default_nettype wire

@@ rtl/size_class_block_pool_allocator.sv @@
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  in_data_i   (req_t: command, alloc_size, free_address)
// out      out_valid_o/out_ready_i out_data_o (rsp_t: status, block_address, pool_index,
//                                               free_count)
// cfg      cfg_valid_i/cfg_ready_o cfg_data_i (blocks_per_pool)
// One item at a time: allocate runs lookup, create, serve, multiply and address add;
// free runs lookup, an 8-step serial divide, then check and push, or ends after lookup
// for an address outside every pool.
// A finished item waits in the output register; the next item is accepted meanwhile
// and its result is held back until the output register frees.
// Reset clears the pool table and bump pointer; stack memory needs no clearing.
// Top level: joins scbpa_ctrl and scbpa_dp and holds the output register.
`default_nettype none
module size_class_block_pool_allocator import scbpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic commit, out_free;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  scbpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_free_i(out_free), .commit_o(commit), .sts_i(sts), .cmd_o(cmd)
  );

  scbpa_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i), .cfg_data_i,
    .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) out_q <= rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (!out_valid_q || out_ready_i)) else $error("commit over pending item");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= 3'd5)) else $error("bad status code");
  a_free_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_q.status == ST_OK || out_q.block_address == '0))
    else $error("address on error");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accept while busy");
`endif

endmodule
`default_nettype wire
